@@ src/btsl_pkg.sv @@
// ----------------------------------------------------------------------------
// btsl_pkg
// Shared types, constants and the arctangent table for the bearing tracker
// ----------------------------------------------------------------------------
package btsl_pkg;

  localparam int COORD_BITS   = 16;
  localparam int MAG_W        = COORD_BITS;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_LIMIT = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int STEP_W       = $clog2(ATAN_ENTRIES + 1);
  localparam int PREC_SHIFT   = 24;
  localparam int ANG_FRAC     = 20;
  localparam int CW_W         = MAG_W + PREC_SHIFT + 4;
  localparam int ATAN_W       = 27;
  localparam int Z_W          = 28;
  localparam int ANG_W        = 7;
  localparam int DEG_W        = 9;
  localparam int SPD_W        = 9;
  localparam int CFG_W        = 9;

  localparam logic [DEG_W-1:0] DEG_360 = DEG_W'(360);
  localparam logic [DEG_W-1:0] DEG_181 = DEG_W'(181);
  localparam logic [DEG_W-1:0] DEG_180 = DEG_W'(180);
  localparam logic [DEG_W-1:0] DEG_179 = DEG_W'(179);
  localparam logic [ANG_W-1:0] ANG_90  = ANG_W'(90);
  localparam logic [ANG_W-1:0] ANG_89  = ANG_W'(89);
  localparam logic [ANG_W-1:0] ANG_45  = ANG_W'(45);
  localparam logic [ANG_W-1:0] ANG_0   = ANG_W'(0);

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } turn_dir_e;

  typedef enum logic {
    REG_TURN_SPEED  = 1'b0,
    REG_INIT_TARGET = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic             done;
    logic [ANG_W-1:0] angle;
  } cordic_res_t;

  // atan(2^-i) in degrees, Q.20, rounded to nearest
  function automatic logic [ATAN_W-1:0] atan_q20(input logic [STEP_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    unique case (idx)
      STEP_W'(0):  v = ATAN_W'(47185920);
      STEP_W'(1):  v = ATAN_W'(27855475);
      STEP_W'(2):  v = ATAN_W'(14718068);
      STEP_W'(3):  v = ATAN_W'(7471121);
      STEP_W'(4):  v = ATAN_W'(3750058);
      STEP_W'(5):  v = ATAN_W'(1876857);
      STEP_W'(6):  v = ATAN_W'(938658);
      STEP_W'(7):  v = ATAN_W'(469357);
      STEP_W'(8):  v = ATAN_W'(234682);
      STEP_W'(9):  v = ATAN_W'(117342);
      STEP_W'(10): v = ATAN_W'(58671);
      STEP_W'(11): v = ATAN_W'(29335);
      STEP_W'(12): v = ATAN_W'(14668);
      STEP_W'(13): v = ATAN_W'(7334);
      STEP_W'(14): v = ATAN_W'(3667);
      STEP_W'(15): v = ATAN_W'(1833);
      STEP_W'(16): v = ATAN_W'(917);
      STEP_W'(17): v = ATAN_W'(458);
      STEP_W'(18): v = ATAN_W'(229);
      STEP_W'(19): v = ATAN_W'(115);
      STEP_W'(20): v = ATAN_W'(57);
      STEP_W'(21): v = ATAN_W'(29);
      STEP_W'(22): v = ATAN_W'(14);
      STEP_W'(23): v = ATAN_W'(7);
      default:     v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ src/btsl_cordic.sv @@
// ----------------------------------------------------------------------------
// btsl_cordic
// Iterative CORDIC vectoring: first-quadrant angle of (ax, ay) in whole degrees
// ----------------------------------------------------------------------------
module btsl_cordic
  import btsl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [MAG_W-1:0] ax_i,
  input  logic [MAG_W-1:0] ay_i,
  output cordic_res_t      res_o
);

  logic signed [CW_W-1:0] x_q, x_d, y_q, y_d, xs, ys;
  logic signed [Z_W-1:0]  z_q, z_d, atan_s, z_deg;
  logic [STEP_W-1:0]      step_q, step_d;
  logic                   busy_q, busy_d, done_q, done_d, fin;
  logic [ANG_W-1:0]       angle_q, angle_d;

  assign xs     = x_q >>> step_q;
  assign ys     = y_q >>> step_q;
  assign atan_s = signed'(Z_W'(atan_q20(step_q)));
  assign fin    = (step_q == STEP_W'(CORDIC_LIMIT)) || (y_q == '0);
  assign z_deg  = z_q >>> ANG_FRAC;

  always_comb begin
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    step_d  = step_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    angle_d = angle_q;
    if (start_i) begin
      x_d    = $signed({{(CW_W-MAG_W){1'b0}}, ax_i}) <<< PREC_SHIFT;
      y_d    = $signed({{(CW_W-MAG_W){1'b0}}, ay_i}) <<< PREC_SHIFT;
      z_d    = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (fin) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (z_q < 0) begin
          angle_d = ANG_0;
        end else if (z_deg > $signed(Z_W'(ANG_89))) begin
          angle_d = ANG_89;
        end else begin
          angle_d = z_deg[ANG_W-1:0];
        end
      end else begin
        step_d = step_q + STEP_W'(1);
        if (y_q > 0) begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + atan_s;
        end else begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - atan_s;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    z_q     <= z_d;
    step_q  <= step_d;
    angle_q <= angle_d;
  end

  assign res_o.done  = done_q;
  assign res_o.angle = angle_q;

endmodule

@@ src/bearing_tracking_slew_limiter.sv @@
// ----------------------------------------------------------------------------
// bearing_tracking_slew_limiter
// Target bearing by CORDIC and slew-limited heading, not a new request each tick
// ----------------------------------------------------------------------------
// Each request carries the current heading and, when has_target is set, own
// and target positions; the bearing atan2(dy,dx) in whole degrees becomes the
// stored aim angle, and the heading then turns toward it along the shorter arc
// by at most turn_speed degrees, counterclockwise on a 180 degree tie. One
// request is in flight at a time and in_stall_o stays high while it is worked
// on. With no target a request goes straight to S_DONE; bearings on an axis
// or a diagonal pass through S_MAP, and all others first run the 16-step
// CORDIC vectoring loop on a single shift-and-add unit in S_CORDIC. The
// result sits in an output register, so the next request can be accepted
// while it waits. Writing initial_target_angle also loads the aim angle.
// ----------------------------------------------------------------------------
module bearing_tracking_slew_limiter
  import btsl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  has_target_i,
  input  logic [COORD_BITS-1:0] own_x_i,
  input  logic [COORD_BITS-1:0] own_y_i,
  input  logic [COORD_BITS-1:0] target_x_i,
  input  logic [COORD_BITS-1:0] target_y_i,
  input  logic [DEG_W-1:0]      current_heading_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [DEG_W-1:0]      new_heading_o,
  output logic [1:0]            turn_direction_o,
  output logic                  on_target_o,
  output logic [DEG_W-1:0]      aim_angle_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CORDIC = 4'b0010,
    S_MAP    = 4'b0100,
    S_DONE   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [SPD_W-1:0] turn_speed_q;
  logic [DEG_W-1:0] aim_q, cfg_norm, mapped;
  logic             in_acc, exact_q, nx_q, ny_q, cordic_start, is_exact;
  logic [ANG_W-1:0] a_q, exact_a;
  logic [DEG_W-1:0] hd_q;
  logic [MAG_W-1:0] ax, ay;
  logic signed [COORD_BITS:0] dx, dy;
  cordic_res_t      cres;

  logic [DEG_W-1:0]  my, cw, ccw, nh;
  logic [DEG_W:0]    up_sum;
  logic [DEG_W+1:0]  dn_sum;
  turn_dir_e         dir;

  logic              out_valid_q, load_out;
  logic [DEG_W-1:0]  out_nh_q, out_aim_q;
  turn_dir_e         out_dir_q;
  logic              out_on_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // relative position and magnitudes
  assign dx = $signed({target_x_i[COORD_BITS-1], target_x_i})
            - $signed({own_x_i[COORD_BITS-1], own_x_i});
  assign dy = $signed({target_y_i[COORD_BITS-1], target_y_i})
            - $signed({own_y_i[COORD_BITS-1], own_y_i});
  assign ax = dx[COORD_BITS] ? MAG_W'(-dx) : dx[MAG_W-1:0];
  assign ay = dy[COORD_BITS] ? MAG_W'(-dy) : dy[MAG_W-1:0];

  always_comb begin
    is_exact = 1'b1;
    exact_a  = ANG_0;
    priority if (ay == '0) begin
      exact_a = ANG_0;
    end else if (ax == '0) begin
      exact_a = ANG_90;
    end else if (ax == ay) begin
      exact_a = ANG_45;
    end else begin
      is_exact = 1'b0;
    end
  end

  assign cordic_start = in_acc && has_target_i && !is_exact;

  btsl_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .ax_i    (ax),
    .ay_i    (ay),
    .res_o   (cres)
  );

  // quadrant mapping
  always_comb begin
    unique case ({nx_q, ny_q})
      2'b00:   mapped = DEG_W'(a_q);
      2'b10:   mapped = (exact_q ? DEG_180 : DEG_179) - DEG_W'(a_q);
      2'b01:   mapped = (a_q == ANG_0) ? '0 : DEG_360 - DEG_W'(a_q);
      default: mapped = (exact_q ? DEG_180 : DEG_181) + DEG_W'(a_q);
    endcase
  end

  assign cfg_norm = (cfg_wdata_i >= DEG_360) ? cfg_wdata_i - DEG_360 : cfg_wdata_i;

  // slew-limited heading
  always_comb begin
    my     = (hd_q >= DEG_360) ? hd_q - DEG_360 : hd_q;
    if (aim_q > my) begin
      cw  = aim_q - my;
      ccw = DEG_360 - cw;
    end else begin
      ccw = my - aim_q;
      cw  = DEG_360 - ccw;
    end
    up_sum = {1'b0, my} + {1'b0, turn_speed_q};
    dn_sum = (DEG_W+2)'(720) + (DEG_W+2)'(my) - (DEG_W+2)'(turn_speed_q);
    nh     = my;
    dir    = DIR_NONE;
    priority if (cw == '0 || ccw == '0) begin
      nh = my;
    end else if (cw < ccw) begin
      dir = DIR_CW;
      priority if (cw < turn_speed_q) begin
        nh = aim_q;
      end else if (up_sum >= (DEG_W+1)'(720)) begin
        nh = DEG_W'(up_sum - (DEG_W+1)'(720));
      end else if (up_sum >= (DEG_W+1)'(360)) begin
        nh = DEG_W'(up_sum - (DEG_W+1)'(360));
      end else begin
        nh = up_sum[DEG_W-1:0];
      end
    end else begin
      dir = DIR_CCW;
      priority if (ccw < turn_speed_q) begin
        nh = aim_q;
      end else if (dn_sum >= (DEG_W+2)'(720)) begin
        nh = DEG_W'(dn_sum - (DEG_W+2)'(720));
      end else if (dn_sum >= (DEG_W+2)'(360)) begin
        nh = DEG_W'(dn_sum - (DEG_W+2)'(360));
      end else begin
        nh = dn_sum[DEG_W-1:0];
      end
    end
    if (nh == my) begin
      dir = DIR_NONE;
    end
  end

  assign load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!has_target_i) begin
            state_d = S_DONE;
          end else if (is_exact) begin
            state_d = S_MAP;
          end else begin
            state_d = S_CORDIC;
          end
        end
      end
      S_CORDIC: begin
        if (cres.done) begin
          state_d = S_MAP;
        end
      end
      S_MAP: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      turn_speed_q  <= SPD_W'(5);
      aim_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_TURN_SPEED:  turn_speed_q <= cfg_wdata_i;
          REG_INIT_TARGET: aim_q        <= cfg_norm;
          default: ;
        endcase
      end else if (state_q == S_MAP) begin
        aim_q <= mapped;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hd_q    <= current_heading_i;
      nx_q    <= dx[COORD_BITS];
      ny_q    <= dy[COORD_BITS];
      exact_q <= is_exact;
      a_q     <= exact_a;
    end else if (state_q == S_CORDIC && cres.done) begin
      a_q <= cres.angle;
    end
    if (load_out) begin
      out_nh_q  <= nh;
      out_dir_q <= dir;
      out_on_q  <= (nh == aim_q);
      out_aim_q <= aim_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign new_heading_o    = out_nh_q;
  assign turn_direction_o = out_dir_q;
  assign on_target_o      = out_on_q;
  assign aim_angle_o      = out_aim_q;

endmodule

@@ src/btsl_checker.sv @@
// ----------------------------------------------------------------------------
// btsl_checker
// Port-level checks for the bearing tracker, bound to the top level
// ----------------------------------------------------------------------------
module btsl_checker
  import btsl_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_we_i,
  input logic                  cfg_idx_i,
  input logic [CFG_W-1:0]      cfg_wdata_i,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  has_target_i,
  input logic [COORD_BITS-1:0] own_x_i,
  input logic [COORD_BITS-1:0] own_y_i,
  input logic [COORD_BITS-1:0] target_x_i,
  input logic [COORD_BITS-1:0] target_y_i,
  input logic [DEG_W-1:0]      current_heading_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [DEG_W-1:0]      new_heading_o,
  input logic [1:0]            turn_direction_o,
  input logic                  on_target_o,
  input logic [DEG_W-1:0]      aim_angle_o
);

  // one request in flight
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while idle did not make the block busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (new_heading_o < DEG_360) && (aim_angle_o < DEG_360)
                    && (turn_direction_o != 2'd3))
    else $error("result out of range");

  a_on_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (on_target_o == (new_heading_o == aim_angle_o)))
    else $error("on_target disagrees with heading and aim");

endmodule

bind bearing_tracking_slew_limiter btsl_checker u_btsl_checker (.*);
